// ===== rtl/lshd_pkg.sv =====
package lshd_pkg;

    localparam int CHANNELS      = 16;
    localparam int CH_BITS       = 4;
    localparam int SAMPLE_BITS   = 10;
    localparam int MARGIN_BITS   = 6;
    localparam int NOTE_BITS     = 6;
    localparam int FIFTHS_BITS   = 4;
    localparam int RECIP_BITS    = 11;
    localparam int MARGIN_SHIFT  = 15;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam int CAL_W  = SAMPLE_BITS + MARGIN_BITS;
    localparam int HIST_W = 2 * SAMPLE_BITS;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    // Division by 26 is done as a multiplication by ceil(2^15 / 26) and a shift.
    localparam logic [RECIP_BITS-1:0] MARGIN_RECIP = RECIP_BITS'(((1 << MARGIN_SHIFT) + 25) / 26);

    localparam logic [FIFTHS_BITS:0] FIFTH_STEP = (FIFTHS_BITS + 1)'(7);
    localparam logic [FIFTHS_BITS:0] FIFTHS_MOD = (FIFTHS_BITS + 1)'(12);

    localparam logic [SAMPLE_BITS-1:0] DROP_RESET = SAMPLE_BITS'(20);
    localparam logic [SAMPLE_BITS:0]   RISE_RESET = (SAMPLE_BITS + 1)'(-5);

    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    localparam logic REG_DROP_THRESHOLD = 1'b0;
    localparam logic REG_RISE_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic [CH_BITS-1:0]     channel;
        logic                   last;
        logic                   shadow;
        logic                   hit;
        logic [NOTE_BITS-1:0]   note;
        logic [SAMPLE_BITS-1:0] depth;
    } chan_res_t;

    function automatic logic [NOTE_BITS-1:0] note_of_channel(input logic [CH_BITS-1:0] ch);
        logic [NOTE_BITS-1:0] note;
        case (ch)
            4'd0:    note = 6'd0;
            4'd1:    note = 6'd2;
            4'd2:    note = 6'd4;
            4'd3:    note = 6'd7;
            4'd4:    note = 6'd9;
            4'd5:    note = 6'd12;
            4'd6:    note = 6'd14;
            4'd7:    note = 6'd16;
            4'd8:    note = 6'd19;
            4'd9:    note = 6'd21;
            4'd10:   note = 6'd24;
            4'd11:   note = 6'd26;
            4'd12:   note = 6'd28;
            4'd13:   note = 6'd31;
            4'd14:   note = 6'd33;
            4'd15:   note = 6'd36;
            default: note = 6'd0;
        endcase
        return note;
    endfunction

endpackage

// ===== rtl/lshd_in_if.sv =====
interface lshd_in_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [lshd_pkg::CH_BITS-1:0]     channel;
    logic [lshd_pkg::SAMPLE_BITS-1:0] raw_level;

    modport source (output valid, output opcode, output channel, output raw_level, input ready);
    modport sink (input valid, input opcode, input channel, input raw_level, output ready);
endinterface

// ===== rtl/lshd_out_if.sv =====
interface lshd_out_if;
    logic                            valid;
    logic                            ready;
    logic [lshd_pkg::SAMPLE_BITS-1:0] level_out;
    logic [lshd_pkg::CH_BITS-1:0]     channel_out;
    logic                            frame_done;
    logic                            hit_valid;
    logic [lshd_pkg::NOTE_BITS-1:0]   hit_note;
    logic [lshd_pkg::SAMPLE_BITS-1:0] hit_depth;
    logic                            step_valid;
    logic [lshd_pkg::FIFTHS_BITS-1:0] fifths_position;

    modport source (
        output valid, output level_out, output channel_out, output frame_done,
        output hit_valid, output hit_note, output hit_depth, output step_valid,
        output fifths_position, input ready
    );
    modport sink (
        input valid, input level_out, input channel_out, input frame_done,
        input hit_valid, input hit_note, input hit_depth, input step_valid,
        input fifths_position, output ready
    );
endinterface

// ===== rtl/light_sensor_hit_detector_unit.sv =====
// Light-sensor hit detector. Each transfer on the sample channel carries one calibrate or
// measure item for one sensor channel and yields exactly one transfer on the result channel,
// registered as it leaves stage one. The block takes one item every cycle unless the result
// channel stalls: the per-channel baseline, margin and sample history live in two small
// synchronous memories that are read when an item is taken and written back as it leaves
// stage one, with a write on the same edge as a read of that channel forwarded, so
// back-to-back items on any channels run at full rate. A frame closes on the measure item of
// the last channel, reporting the lowest hit channel's note and drop and the fifths position.
// The user must write the thresholds over the APB port only when idle; the block won't check.
module light_sensor_hit_detector_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    lshd_in_if.sink                             sample,
    lshd_out_if.source                          result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lshd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lshd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lshd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import lshd_pkg::*;

    logic [SAMPLE_BITS-1:0]     drop_threshold;
    logic signed [SAMPLE_BITS:0] rise_threshold;
    chan_res_t                  res;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic advance;

    logic                   any_shadow_reg;
    logic                   any_shadow_next;
    logic                   hit_found_reg;
    logic                   hit_found_next;
    logic [NOTE_BITS-1:0]   hit_note_reg;
    logic [NOTE_BITS-1:0]   hit_note_next;
    logic [SAMPLE_BITS-1:0] hit_depth_reg;
    logic [SAMPLE_BITS-1:0] hit_depth_next;
    logic [FIFTHS_BITS-1:0] fifths_reg;
    logic [FIFTHS_BITS-1:0] fifths_next;
    logic                   latched_reg;
    logic                   latched_next;
    logic                   reported_reg;
    logic                   reported_next;

    logic [SAMPLE_BITS-1:0] level_out_reg;
    logic [CH_BITS-1:0]     channel_out_reg;
    logic                   frame_done_reg;
    logic                   hit_valid_reg;
    logic [NOTE_BITS-1:0]   hit_note_out_reg;
    logic [SAMPLE_BITS-1:0] hit_depth_out_reg;
    logic                   step_valid_reg;
    logic                   step_valid_next;

    logic                   any_now;
    logic                   found_now;
    logic                   take_hit;
    logic [NOTE_BITS-1:0]   note_now;
    logic [SAMPLE_BITS-1:0] depth_now;
    logic [FIFTHS_BITS:0]   fifths_sum;
    logic [FIFTHS_BITS-1:0] fifths_adv;

    lshd_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .drop_threshold (drop_threshold),
        .rise_threshold (rise_threshold)
    );

    lshd_chan u_chan (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .opcode         (sample.opcode),
        .channel        (sample.channel),
        .raw_level      (sample.raw_level),
        .advance        (advance),
        .drop_threshold (drop_threshold),
        .rise_threshold (rise_threshold),
        .res            (res)
    );

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign accept       = sample.valid && sample.ready;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    assign any_now   = any_shadow_reg || res.shadow;
    assign take_hit  = res.hit && (!hit_found_reg || (res.note < hit_note_reg));
    assign found_now = hit_found_reg || res.hit;
    assign note_now  = take_hit ? res.note : hit_note_reg;
    assign depth_now = take_hit ? res.depth : hit_depth_reg;

    assign fifths_sum = {1'b0, fifths_reg} + FIFTH_STEP;
    assign fifths_adv = (fifths_sum >= FIFTHS_MOD) ? FIFTHS_BITS'(fifths_sum - FIFTHS_MOD)
                                                   : fifths_sum[FIFTHS_BITS-1:0];

    always_comb
    begin
        any_shadow_next = any_shadow_reg;
        hit_found_next  = hit_found_reg;
        hit_note_next   = hit_note_reg;
        hit_depth_next  = hit_depth_reg;
        fifths_next     = fifths_reg;
        latched_next    = latched_reg;
        reported_next   = reported_reg;
        step_valid_next = 1'b0;
        if (advance)
        begin
            if (res.last)
            begin
                if (latched_reg)
                begin
                    if (!any_now)
                    begin
                        latched_next  = 1'b0;
                        reported_next = 1'b0;
                    end
                end
                else if (any_now)
                begin
                    fifths_next  = fifths_adv;
                    latched_next = 1'b1;
                end
                if (latched_next && !reported_next)
                begin
                    step_valid_next = 1'b1;
                    reported_next   = 1'b1;
                end
                any_shadow_next = 1'b0;
                hit_found_next  = 1'b0;
                hit_note_next   = '0;
                hit_depth_next  = '0;
            end
            else
            begin
                any_shadow_next = any_now;
                hit_found_next  = found_now;
                hit_note_next   = note_now;
                hit_depth_next  = depth_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            any_shadow_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            hit_note_reg   <= '0;
            hit_depth_reg  <= '0;
            fifths_reg     <= '0;
            latched_reg    <= 1'b0;
            reported_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            any_shadow_reg <= any_shadow_next;
            hit_found_reg  <= hit_found_next;
            hit_note_reg   <= hit_note_next;
            hit_depth_reg  <= hit_depth_next;
            fifths_reg     <= fifths_next;
            latched_reg    <= latched_next;
            reported_reg   <= reported_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_out_reg     <= res.level;
            channel_out_reg   <= res.channel;
            frame_done_reg    <= res.last;
            hit_valid_reg     <= res.last && found_now;
            hit_note_out_reg  <= (res.last && found_now) ? note_now : '0;
            hit_depth_out_reg <= (res.last && found_now) ? depth_now : '0;
            step_valid_reg    <= step_valid_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.level_out       = level_out_reg;
    assign result.channel_out     = channel_out_reg;
    assign result.frame_done      = frame_done_reg;
    assign result.hit_valid       = hit_valid_reg;
    assign result.hit_note        = hit_note_out_reg;
    assign result.hit_depth       = hit_depth_out_reg;
    assign result.step_valid      = step_valid_reg;
    assign result.fifths_position = fifths_reg;

endmodule

// ===== rtl/lshd_ram.sv =====
module lshd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lshd_cfg.sv =====
module lshd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lshd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lshd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lshd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [lshd_pkg::SAMPLE_BITS-1:0]    drop_threshold,
    output logic signed [lshd_pkg::SAMPLE_BITS:0] rise_threshold
);
    import lshd_pkg::*;

    logic [SAMPLE_BITS-1:0] drop_reg;
    logic [SAMPLE_BITS:0]   rise_reg;
    logic                   reg_sel;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= DROP_RESET;
            rise_reg <= RISE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_DROP_THRESHOLD: drop_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_RISE_THRESHOLD: rise_reg <= pwdata[SAMPLE_BITS:0];
                default:            drop_reg <= drop_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DROP_THRESHOLD: prdata = {{(APB_DATA_BITS-SAMPLE_BITS){1'b0}}, drop_reg};
            REG_RISE_THRESHOLD: prdata = {{(APB_DATA_BITS-SAMPLE_BITS-1){1'b0}}, rise_reg};
            default:            prdata = '0;
        endcase
    end

    assign drop_threshold = drop_reg;
    assign rise_threshold = $signed(rise_reg);

endmodule

// ===== rtl/lshd_chan.sv =====
module lshd_chan (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic                                  opcode,
    input  logic [lshd_pkg::CH_BITS-1:0]          channel,
    input  logic [lshd_pkg::SAMPLE_BITS-1:0]      raw_level,
    input  logic                                  advance,
    input  logic [lshd_pkg::SAMPLE_BITS-1:0]      drop_threshold,
    input  logic signed [lshd_pkg::SAMPLE_BITS:0] rise_threshold,
    output lshd_pkg::chan_res_t                   res
);
    import lshd_pkg::*;

    logic                   op_reg;
    logic [CH_BITS-1:0]     ch_reg;
    logic [SAMPLE_BITS-1:0] raw_reg;

    logic [CHANNELS-1:0] cal_valid_reg;
    logic [CHANNELS-1:0] hist_valid_reg;
    logic                cal_vld_reg;
    logic                hist_vld_reg;
    logic                cal_fwd_reg;
    logic                hist_fwd_reg;
    logic [CAL_W-1:0]    cal_fwd_data_reg;
    logic [HIST_W-1:0]   hist_fwd_data_reg;

    logic                cal_we;
    logic                hist_we;
    logic [CAL_W-1:0]    cal_wdata;
    logic [HIST_W-1:0]   hist_wdata;
    logic [CAL_W-1:0]    cal_rdata;
    logic [HIST_W-1:0]   hist_rdata;
    logic [CAL_W-1:0]    cal_q;
    logic [HIST_W-1:0]   hist_q;

    logic [SAMPLE_BITS+RECIP_BITS-1:0] margin_prod;
    logic [MARGIN_BITS-1:0]            margin_new;
    logic [SAMPLE_BITS-1:0]            base;
    logic [MARGIN_BITS-1:0]            margin;
    logic [SAMPLE_BITS-1:0]            prev;
    logic [SAMPLE_BITS-1:0]            older;
    logic signed [SAMPLE_BITS:0]       base_diff;
    logic                              quiet;
    logic [SAMPLE_BITS-1:0]            level;
    logic signed [SAMPLE_BITS:0]       drop;
    logic signed [SAMPLE_BITS:0]       rise;
    logic                              measure;

    assign measure = (op_reg == OP_MEASURE);
    assign cal_we  = advance && (op_reg == OP_CALIBRATE);
    assign hist_we = advance && measure;

    assign margin_prod = {{RECIP_BITS{1'b0}}, raw_reg} * {{SAMPLE_BITS{1'b0}}, MARGIN_RECIP};
    assign margin_new  = margin_prod[MARGIN_SHIFT +: MARGIN_BITS];
    assign cal_wdata   = {raw_reg, margin_new};
    assign hist_wdata  = {level, prev};

    lshd_ram #(.WIDTH(CAL_W), .DEPTH(CHANNELS)) u_cal_ram (
        .clk   (clk),
        .we    (cal_we),
        .waddr (ch_reg),
        .wdata (cal_wdata),
        .re    (accept),
        .raddr (channel),
        .rdata (cal_rdata)
    );

    lshd_ram #(.WIDTH(HIST_W), .DEPTH(CHANNELS)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ch_reg),
        .wdata (hist_wdata),
        .re    (accept),
        .raddr (channel),
        .rdata (hist_rdata)
    );

    // A write that lands on the same edge as the read of the same entry is forwarded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_valid_reg  <= '0;
            hist_valid_reg <= '0;
            cal_vld_reg    <= 1'b0;
            hist_vld_reg   <= 1'b0;
            cal_fwd_reg    <= 1'b0;
            hist_fwd_reg   <= 1'b0;
        end
        else
        begin
            if (cal_we)
            begin
                cal_valid_reg[ch_reg] <= 1'b1;
            end
            if (hist_we)
            begin
                hist_valid_reg[ch_reg] <= 1'b1;
            end
            if (accept)
            begin
                cal_vld_reg  <= cal_valid_reg[channel];
                hist_vld_reg <= hist_valid_reg[channel];
                cal_fwd_reg  <= cal_we && (ch_reg == channel);
                hist_fwd_reg <= hist_we && (ch_reg == channel);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg            <= opcode;
            ch_reg            <= channel;
            raw_reg           <= raw_level;
            cal_fwd_data_reg  <= cal_wdata;
            hist_fwd_data_reg <= hist_wdata;
        end
    end

    assign cal_q  = cal_fwd_reg ? cal_fwd_data_reg : (cal_vld_reg ? cal_rdata : '0);
    assign hist_q = hist_fwd_reg ? hist_fwd_data_reg : (hist_vld_reg ? hist_rdata : '0);

    assign base   = cal_q[CAL_W-1 -: SAMPLE_BITS];
    assign margin = cal_q[MARGIN_BITS-1:0];
    assign prev   = hist_q[HIST_W-1 -: SAMPLE_BITS];
    assign older  = hist_q[SAMPLE_BITS-1:0];

    assign base_diff = $signed({1'b0, base}) - $signed({1'b0, raw_reg});
    assign quiet     = base_diff < $signed({{(SAMPLE_BITS+1-MARGIN_BITS){1'b0}}, margin});
    assign level     = quiet ? SAMPLE_MAX : raw_reg;

    assign drop = $signed({1'b0, older}) - $signed({1'b0, prev});
    assign rise = $signed({1'b0, prev}) - $signed({1'b0, level});

    always_comb
    begin
        res.level   = measure ? level : raw_reg;
        res.channel = ch_reg;
        res.last    = measure && (ch_reg == CH_BITS'(CHANNELS - 1));
        res.shadow  = measure && (level != SAMPLE_MAX);
        res.hit     = measure && (drop > $signed({1'b0, drop_threshold}))
                      && (rise < rise_threshold);
        res.note    = note_of_channel(ch_reg);
        res.depth   = drop[SAMPLE_BITS-1:0];
    end

endmodule

// ===== verif/lshd_result_checker.sv =====
module lshd_result_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    lshd_in_if                                 smp,
    lshd_out_if                                res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [lshd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [lshd_pkg::APB_DATA_BITS-1:0] pwdata,
    input  logic [lshd_pkg::APB_DATA_BITS-1:0] prdata,
    output int                                 mismatches,
    output int                                 results_due,
    output int                                 frames_closed,
    output int                                 hits_reported,
    output int                                 fifths_steps
);
    timeunit 1ns;
    timeprecision 1ps;

    import lshd_pkg::*;

    localparam int MARGIN_DIV = 26;

    localparam logic [NOTE_BITS-1:0] CHANNEL_NOTE [CHANNELS] = '{
        6'd0, 6'd2, 6'd4, 6'd7, 6'd9, 6'd12, 6'd14, 6'd16,
        6'd19, 6'd21, 6'd24, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36
    };

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic [CH_BITS-1:0]     channel;
        logic                   frame_done;
        logic                   hit_valid;
        logic [NOTE_BITS-1:0]   hit_note;
        logic [SAMPLE_BITS-1:0] hit_depth;
        logic                   step_valid;
        logic [FIFTHS_BITS-1:0] fifths;
    } sensor_result_t;

    logic [SAMPLE_BITS-1:0]        drop_thr;
    logic signed [SAMPLE_BITS:0]   rise_thr;

    logic [SAMPLE_BITS-1:0] base_mem   [CHANNELS];
    logic [MARGIN_BITS-1:0] margin_mem [CHANNELS];
    logic [SAMPLE_BITS-1:0] prev_mem   [CHANNELS];
    logic [SAMPLE_BITS-1:0] older_mem  [CHANNELS];

    logic                   shade_seen;
    logic                   hit_seen;
    logic [NOTE_BITS-1:0]   hit_note_acc;
    logic [SAMPLE_BITS-1:0] hit_depth_acc;
    logic [FIFTHS_BITS-1:0] fifths_pos;
    logic                   fifths_held;
    logic                   fifths_told;

    sensor_result_t due_q [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [CH_BITS-1:0] ch,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s on channel %0d: got %0d, expected %0d",
                                      name, ch, got, want));
    endtask

    // Conditions one sample, updates the channel calibration or history and closes the frame
    // on the measure item of the last channel.
    function automatic sensor_result_t score_sample(input logic op,
                                                   input logic [CH_BITS-1:0] ch,
                                                   input logic [SAMPLE_BITS-1:0] raw);
        sensor_result_t r;
        int lvl;
        int drop;
        int rise;
        logic [NOTE_BITS-1:0] note;
        r = '0;
        r.channel = ch;
        lvl = int'(raw);
        if (op == OP_CALIBRATE)
        begin
            base_mem[ch] = raw;
            margin_mem[ch] = MARGIN_BITS'(int'(raw) / MARGIN_DIV);
        end
        else
        begin
            if (int'(base_mem[ch]) - lvl < int'(margin_mem[ch]))
                lvl = int'(SAMPLE_MAX);
            if (lvl < int'(SAMPLE_MAX))
                shade_seen = 1'b1;
            drop = int'(older_mem[ch]) - int'(prev_mem[ch]);
            rise = int'(prev_mem[ch]) - lvl;
            if (drop > int'(drop_thr) && rise < int'(rise_thr))
            begin
                note = CHANNEL_NOTE[ch];
                if (!hit_seen || note < hit_note_acc)
                begin
                    hit_seen = 1'b1;
                    hit_note_acc = note;
                    hit_depth_acc = SAMPLE_BITS'(drop);
                end
            end
            older_mem[ch] = prev_mem[ch];
            prev_mem[ch] = SAMPLE_BITS'(lvl);
            if (int'(ch) == CHANNELS - 1)
            begin
                r.frame_done = 1'b1;
                if (fifths_held)
                begin
                    if (!shade_seen)
                    begin
                        fifths_held = 1'b0;
                        fifths_told = 1'b0;
                    end
                end
                else if (shade_seen)
                begin
                    fifths_pos = FIFTHS_BITS'((int'(fifths_pos) + int'(FIFTH_STEP))
                                              % int'(FIFTHS_MOD));
                    fifths_held = 1'b1;
                end
                if (fifths_held && !fifths_told)
                begin
                    r.step_valid = 1'b1;
                    fifths_told = 1'b1;
                end
                r.hit_valid = hit_seen;
                if (hit_seen)
                begin
                    r.hit_note = hit_note_acc;
                    r.hit_depth = hit_depth_acc;
                end
                shade_seen = 1'b0;
                hit_seen = 1'b0;
                hit_note_acc = '0;
                hit_depth_acc = '0;
            end
        end
        r.level = SAMPLE_BITS'(lvl);
        r.fifths = fifths_pos;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sensor_result_t got;
        sensor_result_t want;
        int i;
        if (!rst_n)
        begin
            drop_thr = DROP_RESET;
            rise_thr = RISE_RESET;
            for (i = 0; i < CHANNELS; i++)
            begin
                base_mem[i] = '0;
                margin_mem[i] = '0;
                prev_mem[i] = '0;
                older_mem[i] = '0;
            end
            shade_seen = 1'b0;
            hit_seen = 1'b0;
            hit_note_acc = '0;
            hit_depth_acc = '0;
            fifths_pos = '0;
            fifths_held = 1'b0;
            fifths_told = 1'b0;
            due_q.delete();
            mismatches = 0;
            frames_closed = 0;
            hits_reported = 0;
            fifths_steps = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_DROP_THRESHOLD)
                        drop_thr = pwdata[SAMPLE_BITS-1:0];
                    else
                        rise_thr = pwdata[SAMPLE_BITS:0];
                end
                else if (paddr[2] == REG_DROP_THRESHOLD)
                begin
                    if (prdata[SAMPLE_BITS-1:0] !== drop_thr)
                        report_mismatch($sformatf("drop threshold read %0d, expected %0d",
                                                  prdata[SAMPLE_BITS-1:0], drop_thr));
                end
                else if (prdata[SAMPLE_BITS:0] !== rise_thr)
                begin
                    report_mismatch($sformatf("rise threshold read %0d, expected %0d",
                                              $signed(prdata[SAMPLE_BITS:0]), rise_thr));
                end
            end

            if (smp.valid && smp.ready)
            begin
                want = score_sample(smp.opcode, smp.channel, smp.raw_level);
                if (want.frame_done)
                    frames_closed++;
                if (want.hit_valid)
                    hits_reported++;
                if (want.step_valid)
                    fifths_steps++;
                due_q.push_back(want);
            end

            if (res.valid && res.ready)
            begin
                got.level = res.level_out;
                got.channel = res.channel_out;
                got.frame_done = res.frame_done;
                got.hit_valid = res.hit_valid;
                got.hit_note = res.hit_note;
                got.hit_depth = res.hit_depth;
                got.step_valid = res.step_valid;
                got.fifths = res.fifths_position;
                if (due_q.size() == 0)
                begin
                    report_mismatch($sformatf("result transfer on channel %0d with none due",
                                              got.channel));
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("level_out", want.channel, got.level, want.level);
                    check_field("channel_out", want.channel, got.channel, want.channel);
                    check_field("frame_done", want.channel, got.frame_done, want.frame_done);
                    check_field("hit_valid", want.channel, got.hit_valid, want.hit_valid);
                    check_field("hit_note", want.channel, got.hit_note, want.hit_note);
                    check_field("hit_depth", want.channel, got.hit_depth, want.hit_depth);
                    check_field("step_valid", want.channel, got.step_valid, want.step_valid);
                    check_field("fifths_position", want.channel, got.fifths, want.fifths);
                end
            end
        end
        results_due = due_q.size();
    end

endmodule

// ===== verif/light_sensor_hit_detector_unit_tb.sv =====
module light_sensor_hit_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lshd_pkg::*;

    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 160;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int MARGIN_DIV  = 26;
    localparam int DROP_SETTING [N_PHASES] = '{0, 1023, 15, 100, 0, 30};
    localparam int RISE_SETTING [N_PHASES] = '{0, 1023, -1024, -300, 1023, -10};

    logic clk;
    logic rst_n;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    lshd_in_if  smp_if ();
    lshd_out_if res_if ();

    int mismatches;
    int results_due;
    int frames_closed;
    int hits_reported;
    int fifths_steps;

    int items_sent;
    int tx_idle;
    int rx_idle;
    bit hold_result_req;
    logic [SAMPLE_BITS-1:0] cal_level [CHANNELS];

    light_sensor_hit_detector_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lshd_result_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .smp           (smp_if),
        .res           (res_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .mismatches    (mismatches),
        .results_due   (results_due),
        .frames_closed (frames_closed),
        .hits_reported (hits_reported),
        .fifths_steps  (fifths_steps)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The handshake inputs only change at rising edges, so ready is stable at the
    // falling edge and tells whether the next rising edge completes the transfer.
    task automatic send_item(input logic op, input logic [CH_BITS-1:0] ch,
                             input logic [SAMPLE_BITS-1:0] raw);
        logic took;
        while ($urandom_range(99) < tx_idle)
        begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.opcode <= op;
        smp_if.channel <= ch;
        smp_if.raw_level <= raw;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = smp_if.ready;
            @(posedge clk);
        end
        if (op == OP_CALIBRATE)
            cal_level[ch] = raw;
        items_sent++;
    endtask

    task automatic settle();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
                              input logic [APB_DATA_BITS-1:0] data);
        logic took;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = pready;
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_baseline();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
            default: return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 300));
        endcase
    endfunction

    // A shaded sample lies at least one margin below the channel's baseline.
    function automatic logic [SAMPLE_BITS-1:0] pick_level(input logic [CH_BITS-1:0] ch,
                                                          input bit shaded);
        int knee;
        knee = int'(cal_level[ch]) - int'(cal_level[ch]) / MARGIN_DIV;
        if (shaded)
            return SAMPLE_BITS'($urandom_range(knee, 0));
        return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, knee + 1));
    endfunction

    task automatic run_traffic(input int n, input bit pause_mid);
        int first;
        int shade;
        int k;
        int burst;
        first = items_sent;
        while (items_sent - first < n)
        begin
            if (pause_mid && items_sent - first >= n / 2)
            begin
                settle();
                pause_mid = 1'b0;
            end
            k = $urandom_range(99);
            if (k < 10)
            begin
                for (k = 0; k < CHANNELS; k++)
                    send_item(OP_CALIBRATE, CH_BITS'(k), pick_baseline());
            end
            else if (k < 85)
            begin
                case ($urandom_range(4))
                    0, 1:    shade = 0;
                    2:       shade = 15;
                    3:       shade = 40;
                    default: shade = 100;
                endcase
                for (k = 0; k < CHANNELS; k++)
                    send_item(OP_MEASURE, CH_BITS'(k),
                              pick_level(CH_BITS'(k), $urandom_range(99) < shade));
            end
            else
            begin
                burst = $urandom_range(8, 1);
                repeat (burst)
                    send_item(logic'($urandom_range(1)), CH_BITS'($urandom_range(CHANNELS - 1)),
                              SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
            end
        end
    endtask

    initial
    begin : result_sink
        int k;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_result_req)
            begin
                res_if.ready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++)
                    @(posedge clk);
                hold_result_req = 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial
    begin : stimulus
        int ph;
        int k;
        smp_if.valid <= 1'b0;
        smp_if.opcode <= OP_CALIBRATE;
        smp_if.channel <= '0;
        smp_if.raw_level <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        rst_n <= 1'b0;
        items_sent = 0;
        hold_result_req = 1'b0;
        tx_idle = 32;
        rx_idle = 86;
        for (k = 0; k < CHANNELS; k++)
            cal_level[k] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, {REG_DROP_THRESHOLD, 2'b00}, '0);
        apb_access(1'b0, {REG_RISE_THRESHOLD, 2'b00}, '0);

        // Extremes, uncalibrated channels, shadowed and clear frames, and two hits
        // in one frame where the higher channel scores first.
        send_item(OP_CALIBRATE, 4'd0, SAMPLE_MAX);
        send_item(OP_CALIBRATE, 4'd3, 10'd600);
        send_item(OP_CALIBRATE, 4'd9, 10'd600);
        send_item(OP_MEASURE, 4'd1, 10'd0);
        send_item(OP_MEASURE, 4'd2, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd0, 10'd0);
        send_item(OP_MEASURE, 4'd3, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd9, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd3, 10'd100);
        send_item(OP_MEASURE, 4'd9, 10'd50);
        send_item(OP_MEASURE, 4'd15, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd9, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd3, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd15, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd15, 10'd0);
        send_item(OP_MEASURE, 4'd15, 10'd0);
        send_item(OP_CALIBRATE, 4'd15, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd0, SAMPLE_MAX);
        send_item(OP_MEASURE, 4'd15, 10'd682);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            apb_access(1'b1, {REG_DROP_THRESHOLD, 2'b00}, APB_DATA_BITS'(DROP_SETTING[ph]));
            apb_access(1'b1, {REG_RISE_THRESHOLD, 2'b00},
                       APB_DATA_BITS'(RISE_SETTING[ph] & ((1 << (SAMPLE_BITS + 1)) - 1)));
            apb_access(1'b0, {REG_DROP_THRESHOLD, 2'b00}, '0);
            apb_access(1'b0, {REG_RISE_THRESHOLD, 2'b00}, '0);
            case (ph / 2)
                0:
                begin
                    tx_idle = 32;
                    rx_idle = 86;
                end
                1:
                begin
                    tx_idle = 86;
                    rx_idle = 32;
                end
                default:
                begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            if (ph == 0 || ph == 4)
                hold_result_req = 1'b1;
            run_traffic(PHASE_ITEMS, ph == 1 || ph == 3);
        end
        settle();

        $display("Sent %0d sample transfers over %0d threshold settings and three idle patterns.",
                 items_sent, N_PHASES);
        $display("Frames closed: %0d, with a hit: %0d, fifths steps: %0d.",
                 frames_closed, hits_reported, fifths_steps);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #6_000_000;
        $display("Timed out with %0d results still due.", results_due);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
